// ===== sv/tts_pkg.sv =====
// Shared types and constants for the template token splitter.
// Holds the result kind codes, character codes and controller/datapath structs.
// No dependencies.
package tts_pkg;

  localparam int CP_W            = 21;
  localparam int IDX_W           = 10;
  localparam int CNT_W           = 11;
  localparam int MAX_W           = 11;
  localparam int TOKEN_CHARS_DEF = 32;

  localparam logic [MAX_W-1:0] MAX_LIMIT = MAX_W'(1024);
  localparam logic [MAX_W-1:0] MAX_RESET = MAX_W'(64);

  localparam logic [CP_W-1:0] CH_DOLLAR = CP_W'(8'h24);
  localparam logic [CP_W-1:0] CH_OPEN   = CP_W'(8'h7B);
  localparam logic [CP_W-1:0] CH_CLOSE  = CP_W'(8'h7D);
  localparam logic [CP_W-1:0] CH_END    = CP_W'(0);

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_DONE = 2'd1,
    KIND_LONG = 2'd2,
    KIND_MANY = 2'd3
  } kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  accept;
    logic  append;
    logic  append_dollar;
    logic  clear;
    logic  rd_start;
    logic  rd_next;
    logic  count_token;
    logic  load_out;
    kind_t out_kind;
    logic  out_type;
    logic  out_end;
    logic  out_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic c_end;
    logic c_dollar;
    logic c_open;
    logic c_close;
    logic fill_zero;
    logic fill_last;
    logic rd_final;
    logic reach_now;
    logic reach_next;
    logic slot_free;
  } sts_t;

endpackage

// ===== sv/tts_in_if.sv =====
// Input channel of the template token splitter: one character per transaction.
// Depends on tts_pkg for the field width.
interface tts_in_if;
  logic                    valid;
  logic                    ready;
  logic [tts_pkg::CP_W-1:0] code_point;

  modport source (output valid, output code_point, input ready);
  modport sink   (input valid, input code_point, output ready);
endinterface

// ===== sv/tts_out_if.sv =====
// Output channel of the template token splitter: one result per transaction.
// Depends on tts_pkg for the field widths.
interface tts_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 kind;
  logic [tts_pkg::CP_W-1:0]   token_char;
  logic                       token_type;
  logic [tts_pkg::IDX_W-1:0]  token_index;
  logic                       token_end;
  logic [tts_pkg::IDX_W-1:0]  token_total;
  logic                       last;

  modport source (output valid, output kind, output token_char, output token_type,
                  output token_index, output token_end, output token_total,
                  output last, input ready);
  modport sink   (input valid, input kind, input token_char, input token_type,
                  input token_index, input token_end, input token_total,
                  input last, output ready);
endinterface

// ===== sv/template_token_splitter.sv =====
// Template token splitter: one template character in per transaction.
// A plain character is accepted, then decoded; a literal dollar adds a decode and
// a too-long result a result step. A token close reads each buffered character
// (registered buffer read), emits it, and ends with a closing step. Results wait
// in one output register; a new character is taken only after the last is done.
// Synchronous active-high reset: static text mode, empty buffer, zero count, limit 64.
module template_token_splitter #(
  parameter int TOKEN_CHARS = tts_pkg::TOKEN_CHARS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [tts_pkg::MAX_W-1:0] cfg_wdata,
  tts_in_if.sink                    chars,
  tts_out_if.source                 tokens
);

  // Control and status between sequencer and datapath.
  tts_pkg::cmd_t cmd;
  tts_pkg::sts_t sts;

  // Sequencer: owns the template mode (static, after dollar, dynamic, drop)
  // and steps through appends, buffer drains and closing results.
  tts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (chars.valid),
    .in_ready (chars.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Datapath: token buffer, counters, limit register and the output register
  // that parts the result side from the input side.
  tts_datapath #(
    .TOKEN_CHARS (TOKEN_CHARS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .code_point (chars.code_point),
    .out_valid  (tokens.valid),
    .out_ready  (tokens.ready),
    .out_kind   (tokens.kind),
    .out_char   (tokens.token_char),
    .out_type   (tokens.token_type),
    .out_index  (tokens.token_index),
    .out_end    (tokens.token_end),
    .out_total  (tokens.token_total),
    .out_last   (tokens.last)
  );

endmodule

// ===== sv/tts_datapath.sv =====
// Datapath of the template token splitter: character register, token buffer,
// fill and token counters, limit register and output register. Uses tts_pkg.
module tts_datapath #(
  parameter int TOKEN_CHARS = tts_pkg::TOKEN_CHARS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  tts_pkg::cmd_t              cmd,
  output tts_pkg::sts_t              sts,
  input  logic                       cfg_we,
  input  logic [tts_pkg::MAX_W-1:0]  cfg_wdata,
  input  logic [tts_pkg::CP_W-1:0]   code_point,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_kind,
  output logic [tts_pkg::CP_W-1:0]   out_char,
  output logic                       out_type,
  output logic [tts_pkg::IDX_W-1:0]  out_index,
  output logic                       out_end,
  output logic [tts_pkg::IDX_W-1:0]  out_total,
  output logic                       out_last
);

  localparam int AW = (TOKEN_CHARS > 1) ? $clog2(TOKEN_CHARS) : 1;
  localparam int FW = $clog2(TOKEN_CHARS + 1);
  localparam logic [FW-1:0] FILL_LAST = FW'(TOKEN_CHARS - 1);

  logic [tts_pkg::CP_W-1:0]  cur;
  logic [tts_pkg::MAX_W-1:0] max_tokens;
  logic [FW-1:0]             fill;
  logic [tts_pkg::CNT_W-1:0] tokens_done;
  logic [AW-1:0]             rd_idx;
  logic [tts_pkg::CP_W-1:0]  mem [TOKEN_CHARS];
  logic [tts_pkg::CP_W-1:0]  rd_data;
  logic [tts_pkg::CP_W-1:0]  wr_char;
  logic [tts_pkg::MAX_W-1:0] lim;
  logic [tts_pkg::CNT_W:0]   done_plus;

  assign wr_char   = cmd.append_dollar ? tts_pkg::CH_DOLLAR : cur;
  assign lim       = (max_tokens > tts_pkg::MAX_LIMIT) ? tts_pkg::MAX_LIMIT : max_tokens;
  assign done_plus = {1'b0, tokens_done} + (tts_pkg::CNT_W + 1)'(1);

  always_comb begin
    sts.c_end      = (cur == tts_pkg::CH_END);
    sts.c_dollar   = (cur == tts_pkg::CH_DOLLAR);
    sts.c_open     = (cur == tts_pkg::CH_OPEN);
    sts.c_close    = (cur == tts_pkg::CH_CLOSE);
    sts.fill_zero  = (fill == '0);
    sts.fill_last  = (fill == FILL_LAST);
    sts.rd_final   = ((FW'(rd_idx) + FW'(1)) == fill);
    sts.reach_now  = (tokens_done >= lim);
    sts.reach_next = (done_plus >= {1'b0, lim});
    sts.slot_free  = !out_valid || out_ready;
  end

  // Token buffer: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem[fill[AW-1:0]] <= wr_char;
    end
    rd_data <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur <= code_point;
    end
    if (cmd.rd_start) begin
      rd_idx <= '0;
    end else if (cmd.rd_next) begin
      rd_idx <= rd_idx + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_tokens  <= tts_pkg::MAX_RESET;
      fill        <= '0;
      tokens_done <= '0;
    end else begin
      if (cfg_we) begin
        max_tokens <= cfg_wdata;
      end
      if (cmd.clear) begin
        fill        <= '0;
        tokens_done <= '0;
      end else if (cmd.count_token) begin
        fill        <= '0;
        tokens_done <= done_plus[tts_pkg::CNT_W-1:0];
      end else if (cmd.append) begin
        fill <= fill + FW'(1);
      end
    end
  end

  // Output register: hold until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_kind  <= cmd.out_kind;
      out_end   <= cmd.out_end;
      out_last  <= cmd.out_last;
      out_type  <= cmd.out_type;
      if (cmd.out_kind == tts_pkg::KIND_CHAR) begin
        out_char  <= rd_data;
        out_index <= tokens_done[tts_pkg::IDX_W-1:0];
      end else begin
        out_char  <= '0;
        out_index <= '0;
      end
      if (cmd.out_kind == tts_pkg::KIND_DONE) begin
        out_total <= tokens_done[tts_pkg::IDX_W-1:0];
      end else begin
        out_total <= '0;
      end
    end
  end

endmodule

// ===== sv/tts_ctrl.sv =====
// Controller of the template token splitter: template mode and sequencing
// of appends, token drains and closing results. Uses tts_pkg.
module tts_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output tts_pkg::cmd_t cmd,
  input  tts_pkg::sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_RD,
    S_EMIT,
    S_POST,
    S_LONG
  } state_t;

  typedef enum logic [1:0] {
    M_STATIC,
    M_DOLLAR,
    M_DYNAMIC,
    M_DROP
  } mode_t;

  state_t state, state_next;
  mode_t  mode, mode_next;
  logic   tok_type, tok_type_next;
  logic   counted, counted_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.out_kind  = tts_pkg::KIND_CHAR;
    cmd.accept    = in_valid && in_ready;
    state_next    = state;
    mode_next     = mode;
    tok_type_next = tok_type;
    counted_next  = counted;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_IDLE;
        unique case (mode)
          M_DROP: begin
            if (sts.c_end) begin
              cmd.clear = 1'b1;
              mode_next = M_STATIC;
            end
          end
          M_DOLLAR: begin
            if (sts.c_open) begin
              tok_type_next = 1'b0;
              counted_next  = 1'b0;
              if (sts.fill_zero) begin
                state_next = S_POST;
              end else begin
                cmd.rd_start = 1'b1;
                state_next   = S_RD;
              end
            end else begin
              // Literal dollar, then handle this character as static text unless the buffer is full.
              cmd.append        = 1'b1;
              cmd.append_dollar = 1'b1;
              if (sts.fill_last) begin
                state_next = S_LONG;
              end else begin
                mode_next  = M_STATIC;
                state_next = S_DECIDE;
              end
            end
          end
          M_STATIC, M_DYNAMIC: begin
            if (sts.c_end || (mode == M_DYNAMIC && sts.c_close)) begin
              tok_type_next = (mode == M_DYNAMIC);
              counted_next  = 1'b0;
              if (sts.fill_zero) begin
                state_next = S_POST;
              end else begin
                cmd.rd_start = 1'b1;
                state_next   = S_RD;
              end
            end else if (mode == M_STATIC && sts.c_dollar) begin
              mode_next = M_DOLLAR;
            end else begin
              cmd.append = 1'b1;
              if (sts.fill_last) begin
                state_next = S_LONG;
              end
            end
          end
          default: begin
            mode_next = M_STATIC;
          end
        endcase
      end
      S_RD: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.slot_free) begin
          cmd.load_out = 1'b1;
          cmd.out_kind = tts_pkg::KIND_CHAR;
          cmd.out_type = tok_type;
          cmd.out_end  = sts.rd_final;
          cmd.out_last = sts.rd_final && !sts.reach_next && !sts.c_end;
          if (sts.rd_final) begin
            cmd.count_token = 1'b1;
            counted_next    = 1'b1;
            state_next      = S_POST;
          end else begin
            cmd.rd_next = 1'b1;
            state_next  = S_RD;
          end
        end
      end
      S_POST: begin
        priority if (counted && sts.reach_now) begin
          if (sts.slot_free) begin
            cmd.load_out = 1'b1;
            cmd.out_kind = tts_pkg::KIND_MANY;
            cmd.out_last = 1'b1;
            state_next   = S_IDLE;
            if (sts.c_end) begin
              cmd.clear = 1'b1;
              mode_next = M_STATIC;
            end else begin
              mode_next = M_DROP;
            end
          end
        end else if (sts.c_end) begin
          if (sts.slot_free) begin
            cmd.load_out = 1'b1;
            cmd.out_kind = tts_pkg::KIND_DONE;
            cmd.out_last = 1'b1;
            cmd.clear    = 1'b1;
            mode_next    = M_STATIC;
            state_next   = S_IDLE;
          end
        end else begin
          mode_next  = sts.c_open ? M_DYNAMIC : M_STATIC;
          state_next = S_IDLE;
        end
      end
      S_LONG: begin
        if (sts.slot_free) begin
          cmd.load_out = 1'b1;
          cmd.out_kind = tts_pkg::KIND_LONG;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
          if (sts.c_end) begin
            cmd.clear = 1'b1;
            mode_next = M_STATIC;
          end else begin
            mode_next = M_DROP;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      mode     <= M_STATIC;
      tok_type <= 1'b0;
      counted  <= 1'b0;
    end else begin
      state    <= state_next;
      mode     <= mode_next;
      tok_type <= tok_type_next;
      counted  <= counted_next;
    end
  end

endmodule
